FILE: rtl/core/sha256_pkg.sv
// Shared types, constants and tables for the SHA-256 message hasher.
// Holds the round constants, the initial hash words and the control types.
// No dependencies.
package sha256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned LenW   = 61;
    localparam int unsigned PosW   = 4;
    localparam int unsigned RoundW = 6;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned CntW   = 3;

    localparam logic [CntW-1:0]   FullCount = 3'd4;
    localparam logic [WordW-1:0]  PadWord   = 32'h8000_0000;
    localparam logic [PosW-1:0]   PosLen    = 4'd14;
    localparam logic [PosW-1:0]   PosLast   = 4'd15;
    localparam logic [RoundW-1:0] RoundLast = 6'd63;
    localparam logic [IdxW-1:0]   IdxLast   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FIN,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_80,
        PH_ZERO,
        PH_LO,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        WS_INPUT,
        WS_PAD,
        WS_ZERO,
        WS_LEN_HI,
        WS_LEN_LO
    } t_wsel;

    typedef struct packed {
        logic              push;
        t_wsel             wsel;
        logic              accept;
        logic              start;
        logic              round;
        logic [RoundW-1:0] rnd_idx;
        logic              fin;
        logic              rearm;
        logic [IdxW-1:0]   out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_len;
        logic pos_last;
    } t_dp_stat;

    function automatic logic [CntW-1:0] eff_count(input logic [CntW-1:0] vb,
                                                  input logic last);
        if (!last || vb > FullCount) begin
            return FullCount;
        end
        return vb;
    endfunction

    function automatic logic [WordW-1:0] init_hash(input logic [IdxW-1:0] idx);
        logic [WordW-1:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
        logic [WordW-1:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/core/sha256_message_hasher_core.sv
// Top level of the SHA-256 message hasher.
// Connects sha256_ctrl and sha256_dp. Depends on sha256_pkg.
//
// The input channel takes one big-endian message word per item with a
// count of valid leading bytes and a last flag; a word that is not last
// always counts as four bytes. The output channel gives the eight digest
// words of a message, most significant first, with o_digest_done on the
// eighth item.
// The input takes one word per cycle while o_ready is high. The word
// that fills a 16-word block is followed by 64 rounds on the single round
// unit and an update of the chaining value. After the last word the
// padding words go in at one per cycle, held during one or two more
// compressions, and the first digest item is presented after the final
// update of the chaining value. No input item is accepted during
// compression, padding or digest readout.
// A stalled receiver holds the current digest item until it is taken; the
// block then re-arms to the initial hash value for the next message.
// Reset returns the block to idle with the initial hash value and an empty
// message; no clearing pass is needed.
module sha256_message_hasher_core
    import sha256_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WordW-1:0] i_message_word,
    input  logic [CntW-1:0]  i_valid_bytes,
    input  logic             i_last_word,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WordW-1:0] o_digest_word,
    output logic [IdxW-1:0]  o_word_index,
    output logic             o_digest_done
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sha256_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_word_index  (o_word_index),
        .o_digest_done (o_digest_done),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    sha256_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_word (i_message_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_last_word    (i_last_word),
        .o_stat         (stat),
        .o_digest_word  (o_digest_word)
    );

endmodule

FILE: rtl/core/sha256_dp.sv
// Datapath of the SHA-256 message hasher: block window, round logic,
// chaining value and message length. Driven by sha256_ctrl commands.
// Depends on sha256_pkg.
module sha256_dp
    import sha256_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [WordW-1:0] i_message_word,
    input  logic [CntW-1:0]  i_valid_bytes,
    input  logic             i_last_word,
    output t_dp_stat         o_stat,
    output logic [WordW-1:0] o_digest_word
);

    function automatic logic [WordW-1:0] big_s0(input logic [WordW-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WordW-1:0] big_s1(input logic [WordW-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WordW-1:0] sml_s0(input logic [WordW-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [WordW-1:0] sml_s1(input logic [WordW-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    logic [WordW-1:0] r_h [8];
    logic [WordW-1:0] r_v [8];
    logic [WordW-1:0] r_w [16];
    logic [PosW-1:0]  r_pos;
    logic [LenW-1:0]  r_bytes;

    logic [CntW-1:0]  cnt;
    logic [WordW-1:0] in_word;
    logic [WordW-1:0] push_word;
    logic [WordW-1:0] t1;
    logic [WordW-1:0] t2;
    logic [WordW-1:0] ch;
    logic [WordW-1:0] maj;
    logic [WordW-1:0] w_next;

    assign cnt = eff_count(i_valid_bytes, i_last_word);

    always_comb begin
        case (cnt)
            3'd0:    in_word = PadWord;
            3'd1:    in_word = {i_message_word[31:24], 24'h80_0000};
            3'd2:    in_word = {i_message_word[31:16], 16'h8000};
            3'd3:    in_word = {i_message_word[31:8], 8'h80};
            default: in_word = i_message_word;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wsel)
            WS_INPUT:  push_word = in_word;
            WS_PAD:    push_word = PadWord;
            WS_LEN_HI: push_word = r_bytes[60:29];
            WS_LEN_LO: push_word = {r_bytes[28:0], 3'b000};
            default:   push_word = '0;
        endcase
    end

    assign ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1     = r_v[7] + big_s1(r_v[4]) + ch + round_k(i_cmd.rnd_idx) + r_w[0];
    assign t2     = big_s0(r_v[0]) + maj;
    assign w_next = sml_s1(r_w[14]) + r_w[9] + sml_s0(r_w[1]) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= init_hash(IdxW'(i));
                r_v[i] <= '0;
            end
            r_pos   <= '0;
            r_bytes <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_bytes <= r_bytes + LenW'(cnt);
            end
            if (i_cmd.push) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.start) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
            end else if (i_cmd.round) begin
                r_v[0] <= t1 + t2;
                r_v[1] <= r_v[0];
                r_v[2] <= r_v[1];
                r_v[3] <= r_v[2];
                r_v[4] <= r_v[3] + t1;
                r_v[5] <= r_v[4];
                r_v[6] <= r_v[5];
                r_v[7] <= r_v[6];
            end
            if (i_cmd.fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end else if (i_cmd.rearm) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= init_hash(IdxW'(i));
                end
                r_bytes <= '0;
            end
        end
    end

    // The window holds W[t] to W[t+15] during the rounds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_w[r_pos] <= push_word;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_next;
        end
    end

    assign o_stat.pos_len  = (r_pos == PosLen);
    assign o_stat.pos_last = (r_pos == PosLast);
    assign o_digest_word   = r_h[i_cmd.out_idx];

endmodule

FILE: rtl/core/sha256_ctrl.sv
// Controller of the SHA-256 message hasher: input acceptance, padding
// sequence, round counting and digest readout. Depends on sha256_pkg.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [CntW-1:0] i_valid_bytes,
    input  logic            i_last_word,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [IdxW-1:0] o_word_index,
    output logic            o_digest_done,
    input  t_dp_stat        i_stat,
    output t_dp_cmd         o_cmd
);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [RoundW-1:0] r_round, n_round;
    logic [IdxW-1:0]   r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_NONE;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_round       = r_round;
        n_idx         = r_idx;
        o_cmd         = '0;
        o_cmd.wsel    = WS_ZERO;
        o_cmd.rnd_idx = r_round;
        o_cmd.out_idx = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.push   = 1'b1;
                    o_cmd.wsel   = WS_INPUT;
                    o_cmd.accept = 1'b1;
                    if (i_last_word) begin
                        n_phase = (eff_count(i_valid_bytes, i_last_word) == FullCount)
                                  ? PH_80 : PH_ZERO;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                unique case (r_phase)
                    PH_80: begin
                        o_cmd.wsel = WS_PAD;
                        n_phase    = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (i_stat.pos_len) begin
                            o_cmd.wsel = WS_LEN_HI;
                            n_phase    = PH_LO;
                        end else begin
                            o_cmd.wsel = WS_ZERO;
                        end
                    end
                    PH_LO: begin
                        o_cmd.wsel = WS_LEN_LO;
                        n_phase    = PH_DONE;
                    end
                    default: begin
                        o_cmd.push = 1'b0;
                        n_state    = ST_IDLE;
                    end
                endcase
            end
            ST_COMP: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 1'b1;
                if (r_round == RoundLast) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                if (r_phase == PH_DONE) begin
                    n_state = ST_OUT;
                    n_idx   = '0;
                end else if (r_phase == PH_NONE) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == IdxLast) begin
                        o_cmd.rearm = 1'b1;
                        n_phase     = PH_NONE;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // A word written into the final slot completes a block.
        if (o_cmd.push && i_stat.pos_last) begin
            o_cmd.start = 1'b1;
            n_round     = '0;
            n_state     = ST_COMP;
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_word_index  = r_idx;
    assign o_digest_done = (r_idx == IdxLast);

`ifndef SYNTHESIS
    a_comp_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && r_round == RoundLast) |=> (r_state == ST_FIN))
        else $error("Compression did not finish after the last round.");

    a_full_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push && i_stat.pos_last) |=> (r_state == ST_COMP && r_round == '0))
        else $error("A full block did not start compression.");

    a_len_lo_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && r_phase == PH_LO) |-> i_stat.pos_last)
        else $error("Low length word is not in the final slot.");

    a_out_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_phase == PH_DONE))
        else $error("Digest readout without a completed padding sequence.");

    a_readout_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_digest_done) |=> (o_ready && r_phase == PH_NONE))
        else $error("Block did not re-arm after the last digest item.");
`endif

endmodule
